// File: sv/lfsc_pkg.sv
// Shared constants, types and helpers for the line-follower steering control block.
package lfsc_pkg;

    localparam int TICK_MULT_DEFAULT = 1;

    localparam int SENSOR_W = 5;
    localparam int KIND_W   = 2;
    localparam int VAL_W    = 7;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] R_FWD    = 3'd0;
    localparam logic [IDX_W-1:0] R_BRAKE  = 3'd1;
    localparam logic [IDX_W-1:0] R_ADJ_LO = 3'd2;
    localparam logic [IDX_W-1:0] R_ADJ_HI = 3'd3;
    localparam logic [IDX_W-1:0] R_RNEAR  = 3'd4;
    localparam logic [IDX_W-1:0] R_LNEAR  = 3'd5;
    localparam logic [IDX_W-1:0] R_RFAR   = 3'd6;
    localparam logic [IDX_W-1:0] R_LFAR   = 3'd7;

    localparam logic [NUM_REGS-1:0][VAL_W-1:0] REG_RESET = {
        7'd10, 7'd90, 7'd15, 7'd85, 7'd95, 7'd90, 7'd50, 7'd70
    };

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRIVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEER = 2'd2;

    // Sensor patterns and masks
    localparam logic [SENSOR_W-1:0] PAT_CENTER = 5'h1B;
    localparam logic [SENSOR_W-1:0] PAT_ALL    = 5'h1F;
    localparam logic [SENSOR_W-1:0] PAT_NONE   = 5'h00;
    localparam int BIT_LEFT_FAR   = 4;
    localparam int BIT_LEFT_NEAR  = 3;
    localparam int BIT_RIGHT_NEAR = 1;
    localparam int BIT_RIGHT_FAR  = 0;

    localparam logic [VAL_W-1:0] VAL_MAX = 7'd100;
    localparam int ADJ_HIGH_AT = 6;
    localparam int ADJ_LIMIT   = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              reverse;
        logic [VAL_W-1:0]  speed;
        logic [VAL_W-1:0]  steer_x;
        logic [VAL_W-1:0]  throttle;
    } cmd_t;

    function automatic logic [VAL_W-1:0] sat100(input logic [VAL_W:0] v);
        if (v > {1'b0, VAL_MAX})
            return VAL_MAX;
        return v[VAL_W-1:0];
    endfunction

endpackage

// File: sv/lfsc_if.sv
// Valid/ready channel interfaces for sensor samples and motor commands.
interface lfsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [lfsc_pkg::SENSOR_W-1:0] line_sensors;

    modport source (output valid, output line_sensors, input ready);
    modport sink   (input valid, input line_sensors, output ready);
endinterface

interface lfsc_out_if;
    logic                        valid;
    logic                        ready;
    logic [lfsc_pkg::KIND_W-1:0] command_kind;
    logic                        drive_reverse;
    logic [lfsc_pkg::VAL_W-1:0]  drive_speed;
    logic [lfsc_pkg::VAL_W-1:0]  steer_x;
    logic [lfsc_pkg::VAL_W-1:0]  steer_throttle;

    modport source (output valid, output command_kind, output drive_reverse,
                    output drive_speed, output steer_x, output steer_throttle,
                    input ready);
    modport sink   (input valid, input command_kind, input drive_reverse,
                    input drive_speed, input steer_x, input steer_throttle,
                    output ready);
endinterface

// File: sv/line_follower_steering_control_core.sv
// Line-follower steering control: sensor sample in, one motor command out per item.
// One command item comes out for every sensor item, through the input register, then
// the result register, and a new item can enter every cycle unless the output stalls:
// the controller state (forward run, brake burst, adjust timer, post-brake window,
// adjust count, side preference) is updated in the single cycle in which an item
// moves from the input register to the result register. The user must write the
// configuration registers through wr_en/wr_index/wr_data only while the block is idle;
// the block does not enforce this. TICK_MULT scales all tick durations (1..16).
module line_follower_steering_control_core #(
    parameter int TICK_MULT = lfsc_pkg::TICK_MULT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lfsc_in_if.sink                       sensor_in,
    lfsc_out_if.source                    command_out,
    input  logic                          wr_en,
    input  logic [lfsc_pkg::IDX_W-1:0]    wr_index,
    input  logic [lfsc_pkg::VAL_W-1:0]    wr_data
);
    import lfsc_pkg::*;

    localparam logic [7:0] FWD_LIMIT  = 8'(8 * TICK_MULT);
    localparam logic [5:0] BRAKE_LEN  = 6'(2 * TICK_MULT);
    localparam logic [6:0] STOP_BELOW = 7'(2 * TICK_MULT);
    localparam logic [6:0] ADJ_RELOAD = 7'(5 * TICK_MULT);
    localparam logic [7:0] WINDOW_LEN = 8'(10 * TICK_MULT);
    localparam int         PULL_DIV   = 3 * TICK_MULT;
    localparam int         PULL_STEPS = 5;

    logic [NUM_REGS-1:0][VAL_W-1:0] cfg_reg;

    logic                s1_valid_reg;
    logic [SENSOR_W-1:0] s1_line_reg;
    logic                out_valid_reg;
    cmd_t                out_reg;
    cmd_t                res;

    logic [7:0] forward_count_reg, forward_count_next;
    logic [5:0] brake_count_reg, brake_count_next;
    logic [6:0] adjust_timer_reg, adjust_timer_next;
    logic [7:0] window_reg, window_next;
    logic [3:0] adjust_count_reg, adjust_count_next;
    logic       prefer_left_reg, prefer_left_next;

    logic advance;
    assign advance          = s1_valid_reg && (!out_valid_reg || command_out.ready);
    assign sensor_in.ready  = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= REG_RESET;
        else if (wr_en)
            cfg_reg[wr_index] <= wr_data;
    end

    // Steering datapath
    logic [SENSOR_W-1:0] line_eff;
    logic [8:0]          adj_scaled;
    logic                adj_inc;
    logic [3:0]          adj_new;
    logic [2:0]          pull;
    logic [VAL_W-1:0]    thr_pick;
    logic [VAL_W-1:0]    rfar_sat, lfar_sat, rnear_sat, lnear_sat;

    always_comb
    begin
        line_eff   = (s1_line_reg == PAT_ALL) ? PAT_NONE : s1_line_reg;
        adj_scaled = 9'(adjust_count_reg) * 9'(TICK_MULT);
        adj_inc    = adj_scaled < 9'(ADJ_LIMIT);
        thr_pick   = (adj_scaled < 9'(ADJ_HIGH_AT)) ? cfg_reg[R_ADJ_LO] : cfg_reg[R_ADJ_HI];
        adj_new    = adj_inc ? adjust_count_reg + 4'd1 : adjust_count_reg;
        pull       = '0;
        for (int k = 1; k <= PULL_STEPS; k++)
        begin
            if (9'(adj_new) >= 9'(k * PULL_DIV))
                pull = pull + 3'd1;
        end
        if (cfg_reg[R_RFAR] < 7'(pull))
            rfar_sat = '0;
        else
            rfar_sat = sat100({1'b0, cfg_reg[R_RFAR] - 7'(pull)});
        lfar_sat  = sat100({1'b0, cfg_reg[R_LFAR]} + 8'(pull));
        rnear_sat = sat100({1'b0, cfg_reg[R_RNEAR]});
        lnear_sat = sat100({1'b0, cfg_reg[R_LNEAR]});
    end

    always_comb
    begin
        forward_count_next = forward_count_reg;
        brake_count_next   = brake_count_reg;
        adjust_timer_next  = adjust_timer_reg;
        window_next        = window_reg;
        adjust_count_next  = adjust_count_reg;
        prefer_left_next   = prefer_left_reg;
        res                = '0;

        if (s1_line_reg == PAT_CENTER)
        begin
            res.kind  = KIND_DRIVE;
            res.speed = cfg_reg[R_FWD];
            if (forward_count_reg <= FWD_LIMIT)
                forward_count_next = forward_count_reg + 8'd1;
            else
                brake_count_next = BRAKE_LEN;
        end
        else if (brake_count_reg != '0)
        begin
            res.kind           = KIND_DRIVE;
            res.reverse        = 1'b1;
            res.speed          = cfg_reg[R_BRAKE];
            adjust_count_next  = '0;
            forward_count_next = '0;
            window_next        = WINDOW_LEN;
            brake_count_next   = brake_count_reg - 6'd1;
        end
        else if (adjust_timer_reg != '0 && adjust_timer_reg < STOP_BELOW)
        begin
            // stop phase: drive command at speed 0
            res.kind          = KIND_DRIVE;
            adjust_timer_next = adjust_timer_reg - 7'd1;
        end
        else
        begin
            if (adjust_timer_reg == '0)
            begin
                adjust_timer_next = ADJ_RELOAD;
                // lost line inside the post-brake window: reload only
                if (!(s1_line_reg == PAT_NONE && window_reg != '0))
                begin
                    adjust_count_next = adj_new;
                    res.kind          = KIND_STEER;
                    res.throttle      = sat100({1'b0, thr_pick});
                    if (prefer_left_reg)
                    begin
                        if (!line_eff[BIT_RIGHT_FAR])
                        begin
                            res.steer_x      = rfar_sat;
                            prefer_left_next = 1'b0;
                        end
                        else if (!line_eff[BIT_RIGHT_NEAR])
                        begin
                            res.steer_x      = rnear_sat;
                            prefer_left_next = 1'b0;
                        end
                        else if (!line_eff[BIT_LEFT_NEAR])
                            res.steer_x = lnear_sat;
                        else if (!line_eff[BIT_LEFT_FAR])
                            res.steer_x = lfar_sat;
                        else
                            res = '0;
                    end
                    else
                    begin
                        if (!line_eff[BIT_LEFT_FAR])
                        begin
                            res.steer_x      = lfar_sat;
                            prefer_left_next = 1'b1;
                        end
                        else if (!line_eff[BIT_LEFT_NEAR])
                        begin
                            res.steer_x      = lnear_sat;
                            prefer_left_next = 1'b1;
                        end
                        else if (!line_eff[BIT_RIGHT_FAR])
                            res.steer_x = rfar_sat;
                        else if (!line_eff[BIT_RIGHT_NEAR])
                            res.steer_x = rnear_sat;
                        else
                            res = '0;
                    end
                end
            end
            else
                adjust_timer_next = adjust_timer_reg - 7'd1;
            if (window_reg != '0)
                window_next = window_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            forward_count_reg <= '0;
            brake_count_reg   <= '0;
            adjust_timer_reg  <= '0;
            window_reg        <= '0;
            adjust_count_reg  <= '0;
            prefer_left_reg   <= 1'b0;
        end
        else
        begin
            if (sensor_in.ready)
                s1_valid_reg <= sensor_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (command_out.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                forward_count_reg <= forward_count_next;
                brake_count_reg   <= brake_count_next;
                adjust_timer_reg  <= adjust_timer_next;
                window_reg        <= window_next;
                adjust_count_reg  <= adjust_count_next;
                prefer_left_reg   <= prefer_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sensor_in.valid && sensor_in.ready)
            s1_line_reg <= sensor_in.line_sensors;
        if (advance)
            out_reg <= res;
    end

    assign command_out.valid          = out_valid_reg;
    assign command_out.command_kind   = out_reg.kind;
    assign command_out.drive_reverse  = out_reg.reverse;
    assign command_out.drive_speed    = out_reg.speed;
    assign command_out.steer_x        = out_reg.steer_x;
    assign command_out.steer_throttle = out_reg.throttle;

`ifndef NO_ASSERTIONS
    // Both stages full and the output stalled: no new item may enter.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !command_out.ready) |-> !sensor_in.ready)
        else $error("input accepted while pipeline is full");

    // A steer command always reloads the adjust timer.
    a_steer_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.kind == KIND_STEER) |=> (adjust_timer_reg == ADJ_RELOAD))
        else $error("steer command without adjust timer reload");

    // A brake tick opens the post-brake window and clears the adjust count.
    a_brake_window: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.reverse) |=> (window_reg == WINDOW_LEN && adjust_count_reg == '0))
        else $error("brake tick did not arm post-brake window");
`endif

endmodule
